// ===== sv/tbaf_pkg.sv =====
package tbaf_pkg;

   // with rsp never stalled at most four groups wait after any edge
   localparam int QUEUE_DEPTH_DEFAULT = 5;

   // configuration register indexes
   localparam logic [1:0] CSR_ENCODE_MODE  = 2'd0;
   localparam logic [1:0] CSR_START_OFFSET = 2'd1;

   // Thumb BL pair detection
   localparam logic [7:0] BL_MASK   = 8'hF8;
   localparam logic [7:0] BL_HIGH   = 8'hF0;
   localparam logic [7:0] BL_LOW    = 8'hF8;
   localparam logic [2:0] OFS_MASK  = 3'h7;

   // group of one to four output bytes released by a single input item
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } group_type;

endpackage

// ===== sv/tbaf_front.sv =====
module tbaf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic                push_valid,
   input  logic                push_ready,
   output tbaf_pkg::group_type push_group
);
   import tbaf_pkg::*;

   logic [3:0][7:0] win_ff, win_in, win;
   logic [1:0]      held_ff, held_in;
   logic [31:0]     pos_ff, pos_in;
   logic            encode_ff, encode_in;
   logic [31:0]     start_ff, start_in;

   logic            accept, full, match;
   logic [22:0]     src, base, dest;
   logic [3:0][7:0] conv;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      win          = win_ff;
      win[held_ff] = req_tdata;
      full  = (held_ff == 2'd3);
      match = full && ((win[1] & BL_MASK) == BL_HIGH) && ((win[3] & BL_MASK) == BL_LOW);
      // only the low 23 bits of the branch target reach the rewritten bytes
      src   = {win[1][2:0] & OFS_MASK, win[0], win[3][2:0] & OFS_MASK, win[2], 1'b0};
      base  = start_ff[22:0] + pos_ff[22:0] + 23'd4;
      dest  = encode_ff ? (src + base) : (src - base);
      conv[0] = dest[19:12];
      conv[1] = BL_HIGH | {5'b0, dest[22:20]};
      conv[2] = dest[8:1];
      conv[3] = BL_LOW | {5'b0, dest[11:9]};
   end

   always_comb begin
      win_in     = win_ff;
      held_in    = held_ff;
      pos_in     = pos_ff;
      push_valid = 1'b0;
      push_group = '0;
      if (accept) begin
         win_in  = win;
         held_in = held_ff + 2'd1;
         if (match) begin
            push_valid       = 1'b1;
            push_group.bytes = conv;
            push_group.count = 3'd4;
            win_in           = '0;
            held_in          = 2'd0;
            pos_in           = pos_ff + 32'd4;
         end else if (full) begin
            push_valid       = 1'b1;
            push_group.bytes = {16'h0000, win[1], win[0]};
            push_group.count = 3'd2;
            win_in           = {16'h0000, win[3], win[2]};
            held_in          = 2'd2;
            pos_in           = pos_ff + 32'd2;
         end
         if (req_tlast) begin
            // flush everything still held; a BL pair completed by this byte goes out converted
            push_valid      = 1'b1;
            push_group.last = 1'b1;
            if (!match) begin
               push_group.bytes = win;
               push_group.count = {1'b0, held_ff} + 3'd1;
            end
            win_in  = '0;
            held_in = 2'd0;
            pos_in  = '0;
         end
      end
   end

   always_comb begin
      encode_in = encode_ff;
      start_in  = start_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENCODE_MODE:  encode_in = csr_data[0];
            CSR_START_OFFSET: start_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         held_ff   <= '0;
         pos_ff    <= '0;
         encode_ff <= 1'b0;
         start_ff  <= '0;
      end else begin
         win_ff    <= win_in;
         held_ff   <= held_in;
         pos_ff    <= pos_in;
         encode_ff <= encode_in;
         start_ff  <= start_in;
      end
   end

endmodule

// ===== sv/tbaf_queue.sv =====
module tbaf_queue #(
   parameter int DEPTH = tbaf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tbaf_pkg::group_type push_group,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tbaf_pkg::group_type pop_group
);
   import tbaf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_group  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ===== sv/tbaf_back.sv =====
module tbaf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tbaf_pkg::group_type pop_group,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import tbaf_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       at_end, taken;

   assign at_end     = ({1'b0, idx_ff} == (pop_group.count - 3'd1));
   assign taken      = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = pop_valid;
   assign rsp_tdata  = pop_group.bytes[idx_ff];
   assign rsp_tlast  = pop_group.last && at_end;
   assign pop_ready  = taken && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (taken) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== sv/thumb_branch_address_filter_core.sv =====
// Thumb BL branch address filter.
// req_* carries one code byte per item (tlast marks the final byte of a stream);
// rsp_* returns the bytes in stream order, BL pairs rewritten, tlast on the final
// byte of the stream. csr_* writes encode_mode (index 0) and start_offset
// (index 1); write only while the block is idle. csr_ready is always high.
// One byte is accepted per cycle while req_tready is high. Each accepted byte
// releases zero to four bytes as a group into a small group queue; the output side
// drains one byte per cycle while rsp_tready is high, straight from the queue head.
// Sustained rate is one byte per cycle in and out while rsp is not stalled, set by
// the single-byte output port; the queue absorbs the four-byte bursts of a
// converted pair or a flush. When rsp stalls, the queue fills and req_tready
// drops once QUEUE_DEPTH groups wait.
// Reset (synchronous) empties the window and queue and sets both registers to 0.
module thumb_branch_address_filter_core #(
   parameter int QUEUE_DEPTH = tbaf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // out_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tbaf_pkg::*;

   group_type push_group, pop_group;
   logic      push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   tbaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group)
   );

   tbaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group)
   );

   tbaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/tbaf_checker.sv =====
module tbaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // the final byte of a stream always releases output
   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no output after final input byte");

   // input backpressure only comes from a full queue
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with nothing to send");

   // reset leaves the block empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind thumb_branch_address_filter_core tbaf_checker u_tbaf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
